/* rtl/dacw_pkg.sv */
// Package for the DAC waveform sample generator: widths, register and
// state codes, and the quarter-wave sine ROM built at elaboration.
// No dependencies.
`default_nettype none

package dacw_pkg;

	localparam int MAX_SAMPLES     = 1024;
	localparam int MIN_SAMPLES     = 4;
	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
	localparam int QUARTER_LEN     = 1 << QUARTER_BITS;

	localparam int CODE_W  = 12;
	localparam int CNT_W   = 11;                       // samples_per_period register
	localparam int IDX_W   = $clog2(MAX_SAMPLES);      // index within a period
	localparam int PHASE_W = 16;                       // Q0.16 phase
	localparam int STEP_W  = $clog2(PHASE_W);
	localparam int NORM_W  = 16;
	localparam int MAG_W   = 15;
	localparam int FULL_SCALE = 32767;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_DC       = 2'd3
	} wave_t;

	typedef enum logic [1:0] {
		REG_WAVE_TYPE = 2'd0,
		REG_PP_CODE   = 2'd1,
		REG_OFFSET    = 2'd2,
		REG_SAMPLES   = 2'd3
	} cfg_addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SHAPE,
		ST_SCALE,
		ST_EMIT
	} gen_state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef logic [MAG_W-1:0] qsine_rom_t [QUARTER_LEN];

	// 32767 * sin(k * (pi/2) / QUARTER_LEN), Q30 Taylor series truncated each step
	function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		x    = (longint'(k) * HALF_PI_Q30) >> QUARTER_BITS;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		v = ((longint'(sum) * FULL_SCALE) + (64'd1 << 29)) >> 30;
		if (v > FULL_SCALE) begin
			v = FULL_SCALE;
		end
		return v[MAG_W-1:0];
	endfunction

	function automatic qsine_rom_t build_qsine();
		qsine_rom_t rom;
		for (int k = 0; k < QUARTER_LEN; k++) begin
			rom[k] = quarter_sine(k);
		end
		return rom;
	endfunction

	localparam qsine_rom_t QSINE_ROM = build_qsine();
	localparam logic [MAG_W-1:0] SINE_PEAK = quarter_sine(QUARTER_LEN);

endpackage

`default_nettype wire

/* rtl/dacw_if.sv */
// Valid/ready channel interfaces for the DAC waveform sample generator:
// trigger requests, sample results and register writes. Uses dacw_pkg.
`default_nettype none

interface dacw_trig_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface dacw_sample_if;
	import dacw_pkg::*;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] dac_code;
	logic [IDX_W-1:0]  sample_index;
	logic              period_end;

	modport source (output valid, output dac_code, output sample_index,
		output period_end, input ready);
	modport sink   (input valid, input dac_code, input sample_index,
		input period_end, output ready);
endinterface

interface dacw_cfg_if;
	import dacw_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        addr;
	logic [CODE_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* rtl/dacw_phase_div.sv */
// Bit-serial restoring divider: phase = floor(index * 2^16 / count),
// one quotient bit per cycle. Uses dacw_pkg.
`default_nettype none

module dacw_phase_div
	import dacw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire div_ctrl_t          ctrl,
	input  wire logic [IDX_W-1:0]   index,
	input  wire logic [CNT_W-1:0]   count,
	output      logic [PHASE_W-1:0] phase,
	output      div_stat_t          stat
);

	logic [CNT_W-1:0]   rem_q;
	logic [PHASE_W-1:0] quot_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W:0]     rem_shift;
	logic               fits;

	assign rem_shift = {rem_q, 1'b0};
	assign fits      = rem_shift >= {1'b0, count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(PHASE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q  <= CNT_W'(index);
			quot_q <= '0;
		end else if (busy_q) begin
			// remainder stays below count, so the subtraction fits
			rem_q  <= fits ? CNT_W'(rem_shift - {1'b0, count}) : rem_shift[CNT_W-1:0];
			quot_q <= {quot_q[PHASE_W-2:0], fits};
		end
	end

	assign phase     = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* rtl/dac_waveform_sample_generator_unit.sv */
// An accepted trigger starts the bit-serial phase divider, which produces the 16 quotient
// bits; the sequencer then moves through the shape, scale and emit states to a valid sample.
// The idle state takes each trigger; a new trigger is taken while the last sample waits
// in the output register, and the next sample then waits in emit until that register is free.
// Reset: arst_n clears the index, the control state and the registers to
// sine, swing 1241, offset 2048, 1024 samples per period.
`default_nettype none

module dac_waveform_sample_generator_unit
	import dacw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	dacw_trig_if.sink     trigger,
	dacw_sample_if.source sample,
	dacw_cfg_if.sink      cfg
);

	// configuration registers
	wave_t             wave_q;
	logic [CODE_W-1:0] pp_q;
	logic [CODE_W-1:0] offset_q;
	logic [CNT_W-1:0]  spp_q;

	gen_state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_q;

	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] idx_d;
	logic             last_d;
	logic             accept;

	div_ctrl_t          div_ctrl;
	div_stat_t          div_stat;
	logic [PHASE_W-1:0] phase;

	logic shape_load;
	logic scale_load;
	logic emit;

	logic signed [NORM_W-1:0] norm_d, norm_q;
	logic [QUARTER_BITS-1:0]  rom_addr;
	logic [MAG_W-1:0]         sine_mag;
	logic signed [17:0]       tri_v;
	logic [16:0]              phase2;

	logic signed [28:0] prod_q;
	logic [28:0]        biased;
	logic signed [14:0] code_wide;
	logic [CODE_W-1:0]  code;

	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_end_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q   <= WAVE_SINE;
			pp_q     <= CODE_W'(1241);
			offset_q <= CODE_W'(2048);
			spp_q    <= CNT_W'(MAX_SAMPLES);
		end else if (cfg.valid) begin
			unique case (cfg_addr_t'(cfg.addr))
				REG_WAVE_TYPE: wave_q   <= wave_t'(cfg.data[1:0]);
				REG_PP_CODE:   pp_q     <= cfg.data;
				REG_OFFSET:    offset_q <= cfg.data;
				REG_SAMPLES:   spp_q    <= cfg.data[CNT_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		count = spp_q;
		if (spp_q < CNT_W'(MIN_SAMPLES)) begin
			count = CNT_W'(MIN_SAMPLES);
		end else if (spp_q > CNT_W'(MAX_SAMPLES)) begin
			count = CNT_W'(MAX_SAMPLES);
		end
	end

	// wrap to zero on restart or when the period has shrunk to the index or below
	assign accept = trigger.valid && trigger.ready;
	assign idx_d  = (trigger.restart || ({1'b0, cnt_q} >= count)) ? '0 : cnt_q;
	assign last_d = ({1'b0, idx_d} == CNT_W'(count - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= last_d ? '0 : IDX_W'(idx_d + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= idx_d;
			last_q <= last_d;
		end
	end

	dacw_phase_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.index  (idx_d),
		.count  (count),
		.phase  (phase),
		.stat   (div_stat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (trigger.valid) state_d = ST_DIV;
			ST_DIV:   if (div_stat.done) state_d = ST_SHAPE;
			ST_SHAPE: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT:  if (!out_valid_q || sample.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		trigger.ready  = (state_q == ST_IDLE);
		div_ctrl.start = (state_q == ST_IDLE) && trigger.valid;
		shape_load     = (state_q == ST_SHAPE);
		scale_load     = (state_q == ST_SCALE);
		emit           = (state_q == ST_EMIT) && (!out_valid_q || sample.ready);
	end

	// waveform shape from the phase (the square wave from the index)
	assign rom_addr = phase[PHASE_W-3 -: QUARTER_BITS];
	assign phase2   = {phase, 1'b0};

	always_comb begin
		if (phase[PHASE_W-2] && (rom_addr == '0)) begin
			sine_mag = SINE_PEAK;
		end else if (phase[PHASE_W-2]) begin
			sine_mag = QSINE_ROM[QUARTER_BITS'(-rom_addr)];
		end else begin
			sine_mag = QSINE_ROM[rom_addr];
		end
	end

	always_comb begin
		if (phase < PHASE_W'(16384)) begin
			tri_v = signed'({1'b0, phase2});
		end else if (phase < PHASE_W'(49152)) begin
			tri_v = 18'sd65536 - signed'({1'b0, phase2});
		end else begin
			tri_v = signed'({1'b0, phase2}) - 18'sd131072;
		end
		if (tri_v > 18'sd32767) begin
			tri_v = 18'sd32767;
		end else if (tri_v < -18'sd32767) begin
			tri_v = -18'sd32767;
		end
	end

	always_comb begin
		case (wave_q)
			WAVE_SINE: begin
				norm_d = phase[PHASE_W-1] ? -signed'({1'b0, sine_mag})
					: signed'({1'b0, sine_mag});
			end
			WAVE_SQUARE: begin
				norm_d = ({1'b0, idx_q} < (count >> 1)) ? NORM_W'(FULL_SCALE)
					: -NORM_W'(FULL_SCALE);
			end
			WAVE_TRIANGLE: norm_d = tri_v[NORM_W-1:0];
			default:       norm_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (shape_load) begin
			norm_q <= norm_d;
		end
		if (scale_load) begin
			prod_q <= 29'(signed'({1'b0, pp_q}) * norm_q);
		end
	end

	// round half up with a positive bias, then re-center and clamp
	assign biased    = 29'(prod_q + 29'sd32768 + 29'sd268435456);
	assign code_wide = signed'({3'b000, offset_q}) + signed'({2'b00, biased[28:16]})
		- 15'sd4096;

	always_comb begin
		if (code_wide < 15'sd0) begin
			code = '0;
		end else if (code_wide > 15'sd4095) begin
			code = '1;
		end else begin
			code = code_wide[CODE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (sample.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_code_q <= code;
			out_idx_q  <= idx_q;
			out_end_q  <= last_q;
		end
	end

	assign sample.valid        = out_valid_q;
	assign sample.dac_code     = out_code_q;
	assign sample.sample_index = out_idx_q;
	assign sample.period_end   = out_end_q;

`ifndef NO_ASSERTIONS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_stat.busy)
		else $error("divider busy while sequencer idle");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider done outside divide state");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIV) && div_stat.busy)
		else $error("request accepted without starting the divider");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> sample.valid)
		else $error("sample emitted but not presented");
`endif

endmodule

`default_nettype wire

/* tb/tb_dac_waveform_sample_generator_unit.sv */
// Self-checking testbench for dac_waveform_sample_generator_unit: drives sample
// requests and register writes, predicts every sample and checks it on arrival.
// Depends on dacw_pkg and the channel interfaces in dacw_if.sv.

module tb_dac_waveform_sample_generator_unit;
	import dacw_pkg::*;

	typedef struct {
		logic [CODE_W-1:0] code;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} dac_sample_t;

	// Tracks the register settings and the period index, and queues the samples
	// that accepted requests must produce.
	class dac_sample_board;
		wave_t             wave;
		logic [CODE_W-1:0] swing;
		logic [CODE_W-1:0] center;
		logic [CNT_W-1:0]  points;
		int unsigned       next_idx;
		int                sine_lut[1 << SINE_TABLE_BITS];
		dac_sample_t       pending_samples[$];
		int                errors;

		function new();
			int quad;
			int r;
			int v;
			for (int j = 0; j < (1 << SINE_TABLE_BITS); j++) begin
				quad = j >> (SINE_TABLE_BITS - 2);
				r = j % QUARTER_LEN;
				v = (quad & 1) ? quarter_wave(QUARTER_LEN - r) : quarter_wave(r);
				sine_lut[j] = (quad & 2) ? -v : v;
			end
			errors = 0;
			wave = WAVE_SINE;
			swing = 12'd1241;
			center = 12'd2048;
			points = 11'd1024;
			next_idx = 0;
		endfunction

		// Q30 Taylor series of sin on the first quadrant, truncating each term
		function int quarter_wave(int unsigned k);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint unsigned rounded;
			longint          acc;
			x = (longint'(k) * HALF_PI_Q30) / QUARTER_LEN;
			x2 = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			rounded = (longint'(acc) * FULL_SCALE + (64'd1 << 29)) >> 30;
			if (rounded > FULL_SCALE) begin
				rounded = FULL_SCALE;
			end
			return int'(rounded);
		endfunction

		function void set_reg(cfg_addr_t a, logic [CODE_W-1:0] d);
			case (a)
				REG_WAVE_TYPE: wave = wave_t'(d[1:0]);
				REG_PP_CODE:   swing = d;
				REG_OFFSET:    center = d;
				REG_SAMPLES:   points = d[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function dac_sample_t predict_sample(bit restart);
			dac_sample_t s;
			int cnt;
			int idx;
			int phase;
			int norm;
			int code;
			cnt = int'(points);
			if (cnt < MIN_SAMPLES) begin
				cnt = MIN_SAMPLES;
			end
			if (cnt > MAX_SAMPLES) begin
				cnt = MAX_SAMPLES;
			end
			idx = restart ? 0 : int'(next_idx);
			// wrap an index left stranded by a shorter period
			if (idx >= cnt) begin
				idx = 0;
			end
			phase = (idx << PHASE_W) / cnt;
			case (wave)
				WAVE_SINE:   norm = sine_lut[phase >> (PHASE_W - SINE_TABLE_BITS)];
				WAVE_SQUARE: norm = (idx < cnt / 2) ? FULL_SCALE : -FULL_SCALE;
				WAVE_TRIANGLE: begin
					if (phase < 16384) begin
						norm = 2 * phase;
					end else if (phase < 49152) begin
						norm = 65536 - 2 * phase;
					end else begin
						norm = 2 * phase - 131072;
					end
					if (norm > FULL_SCALE) begin
						norm = FULL_SCALE;
					end
					if (norm < -FULL_SCALE) begin
						norm = -FULL_SCALE;
					end
				end
				default: norm = 0;
			endcase
			// bias keeps the product positive so the shift floors
			code = int'(center) + (((int'(swing) * norm + 32768 + (1 << 28)) >>> 16) - 4096);
			if (code < 0) begin
				code = 0;
			end
			if (code > 4095) begin
				code = 4095;
			end
			s.code = code[CODE_W-1:0];
			s.idx = idx[IDX_W-1:0];
			s.last = (idx == cnt - 1);
			next_idx = s.last ? 0 : idx + 1;
			return s;
		endfunction

		function void note_request(bit restart);
			pending_samples.push_back(predict_sample(restart));
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_sample(logic [CODE_W-1:0] code, logic [IDX_W-1:0] idx, logic last);
			dac_sample_t e;
			if (pending_samples.size() == 0) begin
				report($sformatf("unexpected sample code %0d index %0d", code, idx));
			end else begin
				e = pending_samples.pop_front();
				if (code !== e.code) begin
					report($sformatf("dac_code %0d, predicted %0d (index %0d)", code, e.code, e.idx));
				end
				if (idx !== e.idx) begin
					report($sformatf("sample_index %0d, predicted %0d", idx, e.idx));
				end
				if (last !== e.last) begin
					report($sformatf("period_end %0b, predicted %0b (index %0d)", last, e.last, e.idx));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   rx_hold = 0;
	wave_t wave_order[4] = '{WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_DC};

	dac_sample_board sb = new();

	dacw_trig_if   trig_ch();
	dacw_sample_if samp_ch();
	dacw_cfg_if    cfg_ch();

	dac_waveform_sample_generator_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.trigger (trig_ch),
		.sample  (samp_ch),
		.cfg     (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("dac_waveform_sample_generator_unit test failed");
		$finish;
	end

	// receiver: random stalls, or a long hold when asked
	initial begin
		samp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				samp_ch.ready <= 1'b0;
				rx_hold--;
			end else begin
				samp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && samp_ch.valid && samp_ch.ready) begin
			sb.check_sample(samp_ch.dac_code, samp_ch.sample_index, samp_ch.period_end);
		end
	end

	task automatic send_request(input bit restart);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			trig_ch.valid <= 1'b0;
			@(posedge clk);
		end
		trig_ch.valid <= 1'b1;
		trig_ch.restart <= restart;
		do @(posedge clk); while (!trig_ch.ready);
		sb.note_request(restart);
	endtask

	task automatic write_reg(input cfg_addr_t a, input logic [CODE_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= a;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(a, d);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold requests until every sample is back, then let the pipeline empty
	task automatic settle();
		trig_ch.valid <= 1'b0;
		while (sb.pending_samples.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	function automatic logic [CODE_W-1:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 12'd0;
			1: return 12'd4095;
			default: return CODE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0: return CODE_W'($urandom_range(0, 3));
			1: return CODE_W'($urandom_range(1025, 4095));
			2: return 12'd1024;
			3: return CODE_W'($urandom_range(4, 1024));
			default: return CODE_W'($urandom_range(4, 40));
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		trig_ch.valid = 1'b0;
		trig_ch.restart = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = REG_WAVE_TYPE;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-up settings, with a restart in the middle
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		settle();
		// full-scale square on a top offset, period below the minimum
		write_reg(REG_WAVE_TYPE, WAVE_SQUARE);
		write_reg(REG_PP_CODE, 12'd4095);
		write_reg(REG_OFFSET, 12'd4095);
		write_reg(REG_SAMPLES, 12'd0);
		repeat (5) send_request(1'b0);
		settle();
		// triangle clipped at zero, period above the maximum
		write_reg(REG_WAVE_TYPE, WAVE_TRIANGLE);
		write_reg(REG_OFFSET, 12'd0);
		write_reg(REG_SAMPLES, 12'd4095);
		repeat (3) send_request(1'b0);
		settle();
		write_reg(REG_WAVE_TYPE, WAVE_DC);
		write_reg(REG_SAMPLES, 12'd3);
		repeat (2) send_request(1'b0);
		settle();
		// shrink the period below the running index
		write_reg(REG_WAVE_TYPE, WAVE_SINE);
		write_reg(REG_OFFSET, 12'd2048);
		write_reg(REG_SAMPLES, 12'd12);
		repeat (8) send_request(1'b0);
		settle();
		write_reg(REG_SAMPLES, 12'd5);
		send_request(1'b0);

		for (int ph = 0; ph < 12; ph++) begin
			tx_idle_pct = (ph < 4) ? 33 : (ph < 8) ? 57 : 0;
			rx_idle_pct = (ph < 4) ? 57 : (ph < 8) ? 33 : 0;
			settle();
			write_reg(REG_WAVE_TYPE, wave_order[ph % 4]);
			write_reg(REG_PP_CODE, pick_level());
			write_reg(REG_OFFSET, pick_level());
			write_reg(REG_SAMPLES, pick_count());
			if (ph == 10) begin
				rx_hold = 300;
			end
			repeat (40) send_request($urandom_range(0, 19) == 0);
			settle();
			write_reg(REG_SAMPLES, pick_count());
			repeat (42) send_request($urandom_range(0, 19) == 0);
		end
		settle();

		if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
			$display("dac_waveform_sample_generator_unit test passed");
		end else begin
			$display("dac_waveform_sample_generator_unit test failed");
		end
		$finish;
	end

endmodule
